FILE: hw/rtl/etca_pkg.sv
// Shared types and constants for the extended timer with compare targets.
// Used by etca_alu, etca_ctrl and extended_timer_compare_array_top; no dependencies.
package etca_pkg;

    localparam int NUM_TARGETS = 8;
    localparam int IDX_W       = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;

    localparam logic [63:0] TARGET_RESET = 64'h7fff_ffff_ffff_ffff;
    localparam logic [30:0] REMAIN_SAT   = 31'h7fff_ffff;

    typedef enum logic [2:0] {
        REQ_SAMPLE  = 3'd0,
        REQ_SET     = 3'd1,
        REQ_INC     = 3'd2,
        REQ_LIMIT   = 3'd3,
        REQ_ATLEAST = 3'd4,
        REQ_QUERY   = 3'd5
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SAMPLE,
        ST_BOUND,
        ST_UPDATE,
        ST_REPORT
    } t_state;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef struct packed {
        t_state state;
        logic   accept;
        logic   done;
    } t_ctrl;

endpackage

FILE: hw/rtl/etca_alu.sv
// Shared 64-bit add/subtract unit with carry out, used for every timer step.
// Depends on etca_pkg.
module etca_alu (
    input  etca_pkg::t_alu_op i_op,
    input  logic [63:0]       i_a,
    input  logic [63:0]       i_b,
    output logic [63:0]       o_sum,
    output logic              o_carry
);

    logic [64:0] w_full;
    logic [63:0] w_b;

    assign w_b    = (i_op == etca_pkg::ALU_SUB) ? ~i_b : i_b;
    assign w_full = {1'b0, i_a} + {1'b0, w_b} + {64'd0, (i_op == etca_pkg::ALU_SUB)};
    assign o_sum   = w_full[63:0];
    assign o_carry = w_full[64];

endmodule

FILE: hw/rtl/etca_ctrl.sv
// Step sequencer of the extended timer: sample, bound, update, report.
// Depends on etca_pkg.
module etca_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output etca_pkg::t_ctrl  o_ctrl
);

    etca_pkg::t_state r_state;
    etca_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= etca_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            etca_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = etca_pkg::ST_SAMPLE;
                end
            end
            etca_pkg::ST_SAMPLE: n_state = etca_pkg::ST_BOUND;
            etca_pkg::ST_BOUND:  n_state = etca_pkg::ST_UPDATE;
            etca_pkg::ST_UPDATE: n_state = etca_pkg::ST_REPORT;
            etca_pkg::ST_REPORT: n_state = etca_pkg::ST_IDLE;
            default:             n_state = etca_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl.state  = r_state;
        o_ctrl.accept = (r_state == etca_pkg::ST_IDLE) && i_start;
        o_ctrl.done   = (r_state == etca_pkg::ST_REPORT);
    end

endmodule

FILE: hw/rtl/extended_timer_compare_array_top.sv
// Top level of the extended 64-bit timer with an array of compare targets.
// Depends on etca_pkg, etca_alu and etca_ctrl.
//
// Usage: drive a request on the i_ fields and raise start while busy is low;
// the beat is taken at that clock edge and busy rises on the next cycle.
// A sample request rebuilds the 64-bit time from i_counter_sample, bumping
// the high word when the sample is below the stored low word. Set, increment,
// limit and at-least requests update the addressed compare target; a query
// changes nothing. Every request yields exactly one result beat, shown for a
// single cycle with o_done high, reporting on the addressed target after the
// update. An index beyond the target count changes no target and reports zeros.
// The result appears in the same cycle that busy falls, and no new request is
// taken while busy is high. Each request makes four passes through the single
// shared 64-bit add/subtract unit (sample carry, bound, update, remaining time).
// Reset (i_rst_n low, synchronous) clears the time to zero and returns every
// target to 0x7fffffffffffffff at once; no clearing pass is needed.
// The receiver cannot stall: each result beat must be taken when o_done is high.
module extended_timer_compare_array_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          i_req_type,
    input  logic [3:0]          i_timer_index,
    input  logic [31:0]         i_delta_usec,
    input  logic [31:0]         i_counter_sample,
    output logic                o_done,
    output logic                o_index_valid,
    output logic                o_elapsed,
    output logic [30:0]         o_remaining_usec,
    output logic signed [63:0]  o_signed_remaining
);

    etca_pkg::t_ctrl    w_ctrl;
    etca_pkg::t_alu_op  w_op;
    logic [63:0]        w_a;
    logic [63:0]        w_b;
    logic [63:0]        w_sum;
    logic               w_carry;

    logic [2:0]         r_kind;
    logic [3:0]         r_idx;
    logic [31:0]        r_delta;
    logic [31:0]        r_sample;
    logic [63:0]        r_time;
    logic [63:0]        r_bound;
    logic [63:0]        r_tgt;
    logic [63:0]        r_targets [etca_pkg::NUM_TARGETS];
    logic               r_done;
    logic               r_index_valid;
    logic               r_elapsed;
    logic [30:0]        r_remaining;
    logic [63:0]        r_signed_rem;

    logic               w_valid;
    logic [etca_pkg::IDX_W-1:0] w_sel;
    logic               w_writes;
    logic [63:0]        n_tgt;

    etca_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_ctrl  (w_ctrl)
    );

    etca_alu u_alu (
        .i_op    (w_op),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_sum   (w_sum),
        .o_carry (w_carry)
    );

    assign busy    = (w_ctrl.state != etca_pkg::ST_IDLE);
    assign w_valid = ({28'd0, r_idx} < etca_pkg::NUM_TARGETS);
    assign w_sel   = r_idx[etca_pkg::IDX_W-1:0];
    assign w_writes = w_valid && ((r_kind == etca_pkg::REQ_SET) || (r_kind == etca_pkg::REQ_INC)
                    || (r_kind == etca_pkg::REQ_LIMIT) || (r_kind == etca_pkg::REQ_ATLEAST));

    always_comb begin
        w_op = etca_pkg::ALU_ADD;
        w_a  = r_time;
        w_b  = 64'd0;
        unique case (w_ctrl.state)
            etca_pkg::ST_SAMPLE: begin
                w_b = {32'd1, 32'd0};
            end
            etca_pkg::ST_BOUND: begin
                w_b = {32'd0, r_delta};
            end
            etca_pkg::ST_UPDATE: begin
                if (r_kind == etca_pkg::REQ_INC) begin
                    w_a = r_tgt;
                    w_b = {32'd0, r_delta};
                end else begin
                    w_op = etca_pkg::ALU_SUB;
                    w_a  = r_bound;
                    w_b  = r_tgt;
                end
            end
            etca_pkg::ST_REPORT: begin
                w_op = etca_pkg::ALU_SUB;
                w_a  = r_tgt;
                w_b  = r_time;
            end
            default: begin
                w_op = etca_pkg::ALU_ADD;
            end
        endcase
    end

    always_comb begin
        case (r_kind)
            etca_pkg::REQ_SET:     n_tgt = r_bound;
            etca_pkg::REQ_INC:     n_tgt = w_sum;
            etca_pkg::REQ_LIMIT:   n_tgt = w_carry ? r_tgt : r_bound;
            etca_pkg::REQ_ATLEAST: n_tgt = w_carry ? r_bound : r_tgt;
            default:               n_tgt = r_tgt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.accept) begin
            r_kind   <= i_req_type;
            r_idx    <= i_timer_index;
            r_delta  <= i_delta_usec;
            r_sample <= i_counter_sample;
        end
        if (w_ctrl.state == etca_pkg::ST_BOUND) begin
            r_bound <= w_sum;
            r_tgt   <= r_targets[w_sel];
        end
        if (w_ctrl.state == etca_pkg::ST_UPDATE) begin
            r_tgt <= n_tgt;
        end
        if (w_ctrl.state == etca_pkg::ST_REPORT) begin
            r_index_valid <= w_valid;
            if (w_valid) begin
                r_elapsed    <= !w_carry || (w_sum == 64'd0);
                r_signed_rem <= w_sum;
                if (!w_carry) begin
                    r_remaining <= 31'd0;
                end else if (w_sum[63:31] != 33'd0) begin
                    r_remaining <= etca_pkg::REMAIN_SAT;
                end else begin
                    r_remaining <= w_sum[30:0];
                end
            end else begin
                r_elapsed    <= 1'b0;
                r_signed_rem <= 64'd0;
                r_remaining  <= 31'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= 64'd0;
            r_done <= 1'b0;
            for (int k = 0; k < etca_pkg::NUM_TARGETS; k++) begin
                r_targets[k] <= etca_pkg::TARGET_RESET;
            end
        end else begin
            r_done <= w_ctrl.done;
            if ((w_ctrl.state == etca_pkg::ST_SAMPLE) && (r_kind == etca_pkg::REQ_SAMPLE)) begin
                r_time <= {(r_sample < r_time[31:0]) ? w_sum[63:32] : r_time[63:32], r_sample};
            end
            if ((w_ctrl.state == etca_pkg::ST_UPDATE) && w_writes) begin
                r_targets[w_sel] <= n_tgt;
            end
        end
    end

    assign o_done             = r_done;
    assign o_index_valid      = r_index_valid;
    assign o_elapsed          = r_elapsed;
    assign o_remaining_usec   = r_remaining;
    assign o_signed_remaining = r_signed_rem;

    a_result_follows_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(w_ctrl.state) == etca_pkg::ST_REPORT))
        else $error("Result beat without a report step.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("Accepted request did not raise busy.");

    a_invalid_reports_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_index_valid) |-> (!o_elapsed && (o_signed_remaining == 64'sd0)
        && (o_remaining_usec == 31'd0)))
        else $error("Out-of-range index reported nonzero fields.");

    a_elapsed_no_remaining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_elapsed) |-> (o_remaining_usec == 31'd0))
        else $error("Elapsed target reported remaining time.");

endmodule

FILE: tb/etca_report_checker.sv
`timescale 1ns / 1ps
// Result checker for extended_timer_compare_array_top: it tracks the time and the
// compare targets from accepted request beats and compares each result beat.
// Depends on etca_pkg; instantiated by tb_extended_timer_compare_array_top.
module etca_report_checker
    import etca_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [2:0]         i_req_type,
    input  logic [3:0]         i_timer_index,
    input  logic [31:0]        i_delta_usec,
    input  logic [31:0]        i_counter_sample,
    input  logic               o_done,
    input  logic               o_index_valid,
    input  logic               o_elapsed,
    input  logic [30:0]        o_remaining_usec,
    input  logic signed [63:0] o_signed_remaining,
    output int                 o_mismatch_count,
    output int                 o_reports_pending
);

    typedef struct packed {
        logic        index_valid;
        logic        elapsed;
        logic [30:0] remaining_usec;
        logic [63:0] signed_remaining;
    } t_report;

    logic [63:0] time_usec;
    logic [63:0] target_usec [NUM_TARGETS];
    t_report     report_queue [$];

    initial begin
        o_mismatch_count  = 0;
        o_reports_pending = 0;
    end

    task automatic apply_request(input t_req kind, input logic [3:0] idx,
                                 input logic [31:0] delta, input logic [31:0] sample,
                                 output t_report rpt);
        logic [31:0] hi_word;
        logic [63:0] tgt;
        logic [63:0] bound;
        logic [63:0] diff;
        if (kind == REQ_SAMPLE) begin
            hi_word = time_usec[63:32];
            if (sample < time_usec[31:0]) begin
                hi_word = hi_word + 32'd1;
            end
            time_usec = {hi_word, sample};
        end
        rpt = '0;
        if (idx < NUM_TARGETS) begin
            tgt   = target_usec[int'(idx)];
            bound = time_usec + {32'd0, delta};
            case (kind)
                REQ_SET: begin
                    tgt = bound;
                end
                REQ_INC: begin
                    tgt = tgt + {32'd0, delta};
                end
                REQ_LIMIT: begin
                    if (bound < tgt) tgt = bound;
                end
                REQ_ATLEAST: begin
                    if (bound > tgt) tgt = bound;
                end
                default: begin
                end
            endcase
            target_usec[int'(idx)] = tgt;
            diff = tgt - time_usec;
            rpt.index_valid      = 1'b1;
            rpt.elapsed          = (time_usec >= tgt);
            rpt.signed_remaining = diff;
            if (time_usec > tgt) begin
                rpt.remaining_usec = '0;
            end else if (diff > {33'd0, REMAIN_SAT}) begin
                rpt.remaining_usec = REMAIN_SAT;
            end else begin
                rpt.remaining_usec = diff[30:0];
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_report want;
        t_report next_rpt;
        if (!i_rst_n) begin
            time_usec = '0;
            foreach (target_usec[k]) target_usec[k] = TARGET_RESET;
            report_queue.delete();
        end else begin
            if (o_done) begin
                if (report_queue.size() == 0) begin
                    $error("Result beat arrived with no request waiting.");
                    o_mismatch_count++;
                end else begin
                    want = report_queue.pop_front();
                    if (o_index_valid !== want.index_valid) begin
                        $error("index_valid: expected %0d, actual %0d",
                               want.index_valid, o_index_valid);
                        o_mismatch_count++;
                    end
                    if (o_elapsed !== want.elapsed) begin
                        $error("elapsed: expected %0d, actual %0d", want.elapsed, o_elapsed);
                        o_mismatch_count++;
                    end
                    if (o_remaining_usec !== want.remaining_usec) begin
                        $error("remaining_usec: expected %0d, actual %0d",
                               want.remaining_usec, o_remaining_usec);
                        o_mismatch_count++;
                    end
                    if (o_signed_remaining !== want.signed_remaining) begin
                        $error("signed_remaining: expected %0d, actual %0d",
                               $signed(want.signed_remaining), o_signed_remaining);
                        o_mismatch_count++;
                    end
                end
            end
            if (start && !busy) begin
                apply_request(t_req'(i_req_type), i_timer_index, i_delta_usec,
                              i_counter_sample, next_rpt);
                report_queue.push_back(next_rpt);
            end
        end
        o_reports_pending = report_queue.size();
    end

endmodule

FILE: tb/tb_extended_timer_compare_array_top.sv
`timescale 1ns / 1ps
// Top of the testbench for extended_timer_compare_array_top: it drives directed and
// random request beats with random gaps and gives the verdict.
// Depends on etca_pkg, the block's RTL and etca_report_checker.
module tb_extended_timer_compare_array_top;
    import etca_pkg::*;

    localparam int          RANDOM_REQUESTS = 1725;
    localparam int          STALL_LIMIT     = 1000;
    localparam logic [2:0]  REQ_SPARE_6     = 3'd6;
    localparam logic [2:0]  REQ_SPARE_7     = 3'd7;

    logic               i_clk            = 1'b0;
    logic               i_rst_n          = 1'b0;
    logic               start            = 1'b0;
    logic [2:0]         i_req_type       = '0;
    logic [3:0]         i_timer_index    = '0;
    logic [31:0]        i_delta_usec     = '0;
    logic [31:0]        i_counter_sample = '0;
    logic               busy;
    logic               o_done;
    logic               o_index_valid;
    logic               o_elapsed;
    logic [30:0]        o_remaining_usec;
    logic signed [63:0] o_signed_remaining;
    int                 mismatch_count;
    int                 reports_pending;
    int                 stall_cycles     = 0;
    logic               no_idling        = 1'b0;
    logic [31:0]        counter_now      = '0;

    always #4 i_clk = ~i_clk;

    extended_timer_compare_array_top DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_req_type         (i_req_type),
        .i_timer_index      (i_timer_index),
        .i_delta_usec       (i_delta_usec),
        .i_counter_sample   (i_counter_sample),
        .o_done             (o_done),
        .o_index_valid      (o_index_valid),
        .o_elapsed          (o_elapsed),
        .o_remaining_usec   (o_remaining_usec),
        .o_signed_remaining (o_signed_remaining)
    );

    etca_report_checker checker_inst (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_req_type         (i_req_type),
        .i_timer_index      (i_timer_index),
        .i_delta_usec       (i_delta_usec),
        .i_counter_sample   (i_counter_sample),
        .o_done             (o_done),
        .o_index_valid      (o_index_valid),
        .o_elapsed          (o_elapsed),
        .o_remaining_usec   (o_remaining_usec),
        .o_signed_remaining (o_signed_remaining),
        .o_mismatch_count   (mismatch_count),
        .o_reports_pending  (reports_pending)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idling || r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_request(input logic [2:0] kind, input logic [3:0] idx,
                                input logic [31:0] delta, input logic [31:0] sample);
        int gap;
        i_req_type       <= kind;
        i_timer_index    <= idx;
        i_delta_usec     <= delta;
        i_counter_sample <= sample;
        start            <= 1'b1;
        if (kind == REQ_SAMPLE) counter_now = sample;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        int          r;
        logic [2:0]  kind;
        logic [3:0]  idx;
        logic [31:0] delta;
        logic [31:0] sample;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(REQ_QUERY, 4'd0, 32'd0, 32'd0);
        send_request(REQ_SAMPLE, 4'd0, 32'd0, 32'hffff_ffff);
        send_request(REQ_SAMPLE, 4'd15, 32'hffff_ffff, 32'h0000_0000);
        send_request(REQ_SET, 4'd0, 32'd0, 32'hffff_ffff);
        send_request(REQ_SET, 4'd1, 32'hffff_ffff, 32'd0);
        send_request(REQ_SET, 4'd2, 32'h7fff_ffff, 32'd0);
        send_request(REQ_SET, 4'd3, 32'h8000_0000, 32'd0);
        send_request(REQ_SET, 4'd4, 32'h7fff_fffe, 32'd0);
        send_request(REQ_INC, 4'd1, 32'hffff_ffff, 32'd0);
        send_request(REQ_INC, 4'd5, 32'hffff_ffff, 32'd0);
        send_request(REQ_LIMIT, 4'd5, 32'd10, 32'd0);
        send_request(REQ_LIMIT, 4'd1, 32'hffff_ffff, 32'd0);
        send_request(REQ_ATLEAST, 4'd0, 32'd100, 32'd0);
        send_request(REQ_ATLEAST, 4'd1, 32'd0, 32'd0);
        send_request(REQ_SAMPLE, 4'd7, 32'd0, 32'h0000_0200);
        send_request(REQ_QUERY, 4'd0, 32'hffff_ffff, 32'hffff_ffff);
        send_request(REQ_SET, 4'd7, 32'd0, 32'd0);
        send_request(REQ_QUERY, 4'd8, 32'd0, 32'd0);
        send_request(REQ_SET, 4'd15, 32'hffff_ffff, 32'hffff_ffff);
        send_request(REQ_INC, 4'd9, 32'd5, 32'd0);
        send_request(REQ_LIMIT, 4'd12, 32'd0, 32'd0);
        send_request(REQ_ATLEAST, 4'd14, 32'hffff_ffff, 32'd0);
        send_request(REQ_SPARE_6, 4'd3, 32'hffff_ffff, 32'hffff_ffff);
        send_request(REQ_SPARE_7, 4'd7, 32'hffff_ffff, 32'd0);
        send_request(REQ_QUERY, 4'd7, 32'd0, 32'd0);

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            no_idling = ((n / 150) % 4 == 3);
            r = $urandom_range(0, 99);
            if (r < 25) kind = REQ_SAMPLE;
            else if (r < 30) kind = 3'($urandom_range(REQ_SPARE_6, REQ_SPARE_7));
            else kind = 3'($urandom_range(REQ_SET, REQ_QUERY));

            if ($urandom_range(0, 99) < 85) idx = 4'($urandom_range(0, NUM_TARGETS - 1));
            else idx = 4'($urandom_range(NUM_TARGETS, 15));

            r = $urandom_range(0, 99);
            if (r < 45) delta = $urandom_range(0, 5000);
            else if (r < 80) delta = $urandom;
            else if (r < 87) delta = 32'd0;
            else if (r < 93) delta = 32'hffff_ffff;
            else delta = 32'h7fff_fff0 + $urandom_range(0, 31);

            r = $urandom_range(0, 99);
            if (kind != REQ_SAMPLE) sample = $urandom;
            else if (r < 80) sample = counter_now + $urandom_range(0, 3000);
            else if (r < 90) sample = counter_now - $urandom_range(0, 3000);
            else sample = $urandom;

            send_request(kind, idx, delta, sample);
        end
        start <= 1'b0;

        @(posedge i_clk);
        while (reports_pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (mismatch_count == 0 && reports_pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
